// ===== hdl/pbnl_pkg.sv =====
// ----------------------------------------------------------------------------
// pbnl_pkg
// shared types, constants and the log2 segment table for the deviance block
// ----------------------------------------------------------------------------
package pbnl_pkg;

   localparam int LOG_Q        = 24;
   localparam int LOG_SEG_BITS = 6;
   localparam int LOG_SEGS     = 1 << LOG_SEG_BITS;
   localparam int MU_FRAC      = 40;

   localparam logic [31:0] LN2_Q24  = 32'd11629080;
   localparam logic [32:0] LOG_BIAS = 33'(MU_FRAC) << LOG_Q;
   localparam logic [47:0] SUM_MAX  = 48'hFFFF_FFFF_FFFF;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   // register indexes
   localparam logic [7:0] CSR_SIGNAL_AMP     = 8'd0;
   localparam logic [7:0] CSR_BACKGROUND_AMP = 8'd1;

   typedef logic [24:0] seg_tab_type [0:LOG_SEGS];

   typedef struct packed {
      logic [15:0] count;
      logic [24:0] sig_w;
      logic [24:0] bkg_w;
      logic        last;
      logic        count_zero;
   } item_type;

   // log2(1+k/64) in q.24 by repeated squaring
   function automatic seg_tab_type build_seg_tab();
      seg_tab_type tab;
      logic [63:0] y;
      logic [24:0] r;
      for (int k = 0; k < LOG_SEGS; k++) begin
         y = (64'd1 << 30) + (64'(k) << (30 - LOG_SEG_BITS));
         r = '0;
         for (int b = LOG_Q - 1; b >= 0; b--) begin
            y = (y * y) >> 30;
            if (y >= (64'd1 << 31)) begin
               r = r | (25'd1 << b);
               y = y >> 1;
            end
         end
         tab[k] = r;
      end
      tab[LOG_SEGS] = 25'd1 << LOG_Q;
      return tab;
   endfunction

   localparam seg_tab_type SEG_TAB = build_seg_tab();

endpackage

// ===== hdl/pbnl_channels.sv =====
// ----------------------------------------------------------------------------
// pbnl channels
// bin request and deviance response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface pbnl_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] observed_count;
   logic [24:0] signal_weight;
   logic [24:0] background_weight;
   logic        last_bin;

   modport source (output valid, observed_count, signal_weight, background_weight,
                   last_bin, input ready);
   modport sink (input valid, observed_count, signal_weight, background_weight,
                 last_bin, output ready);
endinterface

interface pbnl_rsp_if;
   logic        valid;
   logic        ready;
   logic [47:0] neg2_log_likelihood;
   logic        saturated;
   logic [15:0] terms_added;

   modport source (output valid, neg2_log_likelihood, saturated, terms_added,
                   input ready);
   modport sink (input valid, neg2_log_likelihood, saturated, terms_added,
                 output ready);
endinterface

// ===== hdl/pbnl_front.sv =====
// ----------------------------------------------------------------------------
// pbnl_front
// takes bin words, masks and classifies the count, holds them in a 2-deep queue
// ----------------------------------------------------------------------------
module pbnl_front import pbnl_pkg::*; #(
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   pbnl_req_if.sink    req_chan,
   output logic        head_valid,
   output item_type    head_item,
   input  logic        head_pop
);

   logic [15:0] count_mask;
   item_type    item_in;
   item_type    mem_ff [0:1];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  fill_ff, fill_in;
   logic        push;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         count_mask[i] = (i < COUNT_BITS);
      end
      item_in.count      = req_chan.observed_count & count_mask;
      item_in.sig_w      = req_chan.signal_weight;
      item_in.bkg_w      = req_chan.background_weight;
      item_in.last       = req_chan.last_bin;
      item_in.count_zero = ((req_chan.observed_count & count_mask) == 16'd0);
   end

   assign req_chan.ready = (fill_ff != 2'd2);
   assign push       = req_chan.valid && req_chan.ready;
   assign head_valid = (fill_ff != 2'd0);
   assign head_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = head_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(head_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

// ===== hdl/pbnl_back.sv =====
// ----------------------------------------------------------------------------
// pbnl_back
// sequencer with one shared multiplier: mu, two log2 passes, deviance term, sum
// ----------------------------------------------------------------------------
module pbnl_back import pbnl_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] signal_amplitude,
   input  logic [31:0] background_amplitude,
   input  logic        head_valid,
   input  item_type    head_item,
   output logic        head_pop,
   pbnl_rsp_if.source  rsp_chan
);

   localparam int OUT_SHIFT = LOG_Q - FRAC_BITS;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MUL_S = 4'd1;
   localparam logic [3:0] ST_MUL_B = 4'd2;
   localparam logic [3:0] ST_MU    = 4'd3;
   localparam logic [3:0] ST_NORM  = 4'd4;
   localparam logic [3:0] ST_LUT   = 4'd5;
   localparam logic [3:0] ST_LOGF  = 4'd6;
   localparam logic [3:0] ST_LN    = 4'd7;
   localparam logic [3:0] ST_XL    = 4'd8;
   localparam logic [3:0] ST_BR    = 4'd9;
   localparam logic [3:0] ST_ACC   = 4'd10;

   logic [3:0]  state_ff, state_in;
   item_type    item_ff, item_in;
   logic [57:0] mu_ff, mu_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] norm_ff, norm_in;
   logic [5:0]  exp_ff, exp_in;
   logic [30:0] base_ff, base_in;
   logic [30:0] lm_ff, lm_in;
   logic        phase_ff, phase_in;
   logic [30:0] dmag_ff, dmag_in;
   logic        dneg_ff, dneg_in;
   logic [50:0] term_ff, term_in;
   logic        inf_ff, inf_in;
   logic [47:0] sum_ff, sum_in;
   logic        ovf_ff, ovf_in;
   logic [15:0] cnt_ff, cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_sum_ff, rsp_sum_in;
   logic        rsp_sat_ff, rsp_sat_in;
   logic [15:0] rsp_cnt_ff, rsp_cnt_in;

   logic [31:0] mul_a, mul_b;
   logic [57:0] mu_sum;
   logic [2:0]  lead_zeros;
   logic [5:0]  seg_idx;
   logic [23:0] seg_frac;
   logic [24:0] seg_lo, seg_hi;
   logic [30:0] log_val;
   logic signed [32:0] d_val;
   logic signed [49:0] bracket;
   logic [51:0] sum_add;
   logic        have_term, sum_over;
   logic [47:0] new_sum;
   logic        new_ovf;
   logic [15:0] new_cnt;
   logic        out_free;

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MUL_S: begin
            mul_a = signal_amplitude;
            mul_b = 32'(item_ff.sig_w);
         end
         ST_MUL_B: begin
            mul_a = background_amplitude;
            mul_b = 32'(item_ff.bkg_w);
         end
         ST_LUT: begin
            mul_a = 32'(seg_hi - seg_lo);
            mul_b = 32'(seg_frac);
         end
         ST_LN: begin
            mul_a = 32'(dmag_ff);
            mul_b = LN2_Q24;
         end
         ST_XL: begin
            mul_a = 32'(prod_ff[54:24]);
            mul_b = 32'(item_ff.count);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = 64'(mul_a) * 64'(mul_b);
   end

   always_comb begin
      mu_sum = mu_ff + prod_ff[57:0];
      lead_zeros = 3'd7;
      for (int i = 0; i < 8; i++) begin
         if (norm_ff[56 + i]) begin
            lead_zeros = 3'(7 - i);
         end
      end
      seg_idx  = norm_ff[62:57];
      seg_frac = norm_ff[56:33];
      seg_lo   = SEG_TAB[seg_idx];
      seg_hi   = SEG_TAB[7'({1'b0, seg_idx}) + 7'd1];
      log_val  = base_ff + 31'(prod_ff[48:24]);
      d_val    = $signed({2'b00, log_val}) - $signed({2'b00, lm_ff}) + $signed(LOG_BIAS);
      bracket  = $signed(50'(mu_ff[57:16])) - $signed(50'({item_ff.count, 24'd0}));
      if (dneg_ff) begin
         bracket = bracket - $signed(50'(prod_ff[46:0]));
      end else begin
         bracket = bracket + $signed(50'(prod_ff[46:0]));
      end
      if (bracket < 0) begin
         bracket = '0;
      end

      sum_add   = 52'(sum_ff) + 52'(term_ff);
      sum_over  = (sum_add > 52'(SUM_MAX));
      have_term = inf_ff || (term_ff != 51'd0);
      new_sum   = sum_ff;
      new_ovf   = ovf_ff;
      new_cnt   = cnt_ff;
      if (have_term) begin
         if (inf_ff || sum_over) begin
            new_sum = SUM_MAX;
            new_ovf = 1'b1;
         end else begin
            new_sum = sum_add[47:0];
         end
         if (cnt_ff != COUNT_MAX) begin
            new_cnt = cnt_ff + 16'd1;
         end
      end
      out_free = !rsp_valid_ff || rsp_chan.ready;
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      mu_in        = mu_ff;
      norm_in      = norm_ff;
      exp_in       = exp_ff;
      base_in      = base_ff;
      lm_in        = lm_ff;
      phase_in     = phase_ff;
      dmag_in      = dmag_ff;
      dneg_in      = dneg_ff;
      term_in      = term_ff;
      inf_in       = inf_ff;
      sum_in       = sum_ff;
      ovf_in       = ovf_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_sum_in   = rsp_sum_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      head_pop     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               head_pop = 1'b1;
               item_in  = head_item;
               state_in = ST_MUL_S;
            end
         end
         ST_MUL_S: state_in = ST_MUL_B;
         ST_MUL_B: begin
            mu_in    = prod_ff[57:0];
            state_in = ST_MU;
         end
         ST_MU: begin
            mu_in    = mu_sum;
            term_in  = '0;
            inf_in   = 1'b0;
            state_in = ST_ACC;
            if (item_ff.count_zero) begin
               term_in = 51'({mu_sum[57:16], 1'b0} >> OUT_SHIFT);
            end else if (mu_sum == 58'd0) begin
               inf_in = 1'b1;
            end else begin
               norm_in  = 64'(mu_sum);
               exp_in   = 6'd63;
               phase_in = 1'b0;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (norm_ff[63:56] == 8'd0) begin
               norm_in = norm_ff << 8;
               exp_in  = exp_ff - 6'd8;
            end else begin
               norm_in  = norm_ff << lead_zeros;
               exp_in   = exp_ff - 6'(lead_zeros);
               state_in = ST_LUT;
            end
         end
         ST_LUT: begin
            base_in  = 31'({exp_ff, 24'd0}) + 31'(seg_lo);
            state_in = ST_LOGF;
         end
         ST_LOGF: begin
            if (!phase_ff) begin
               lm_in    = log_val;
               norm_in  = 64'(item_ff.count);
               exp_in   = 6'd63;
               phase_in = 1'b1;
               state_in = ST_NORM;
            end else begin
               dneg_in  = d_val[32];
               dmag_in  = d_val[32] ? 31'(-d_val) : 31'(d_val);
               state_in = ST_LN;
            end
         end
         ST_LN: state_in = ST_XL;
         ST_XL: state_in = ST_BR;
         ST_BR: begin
            term_in  = 51'({bracket[48:0], 1'b0} >> OUT_SHIFT);
            inf_in   = 1'b0;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (!item_ff.last) begin
               sum_in   = new_sum;
               ovf_in   = new_ovf;
               cnt_in   = new_cnt;
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = new_sum;
               rsp_sat_in   = new_ovf;
               rsp_cnt_in   = new_cnt;
               sum_in       = '0;
               ovf_in       = 1'b0;
               cnt_in       = '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         ovf_ff       <= ovf_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      mu_ff      <= mu_in;
      prod_ff    <= prod_in;
      norm_ff    <= norm_in;
      exp_ff     <= exp_in;
      base_ff    <= base_in;
      lm_ff      <= lm_in;
      phase_ff   <= phase_in;
      dmag_ff    <= dmag_in;
      dneg_ff    <= dneg_in;
      term_ff    <= term_in;
      inf_ff     <= inf_in;
      rsp_sum_ff <= rsp_sum_in;
      rsp_sat_ff <= rsp_sat_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.neg2_log_likelihood = rsp_sum_ff;
   assign rsp_chan.saturated           = rsp_sat_ff;
   assign rsp_chan.terms_added         = rsp_cnt_ff;

endmodule

// ===== hdl/poisson_binned_neg2_loglik.sv =====
// ----------------------------------------------------------------------------
// poisson_binned_neg2_loglik
// binned poisson -2 ln L (baker-cousins) accumulator over histogram bins
// ----------------------------------------------------------------------------
// each bin word on req_chan carries an observed count x and q0.24 signal and
// background shape weights; the block forms mu = S*sig + B*bkg from the two
// q16.16 amplitude registers and adds 2*(mu - x + x*ln(x/mu)), or 2*mu for an
// empty bin, to a saturating q32.16 sum. the bin flagged last_bin produces one
// word on rsp_chan with the sum, the saturation flag and the number of bins
// that added a term, and the sum starts over. a two-word queue sits between
// the input side and the sequencer, so bins keep arriving while one is worked
// on and a finished result waits in its own output register. an empty bin or
// a zero-expectation bin skips both log2 passes; any other bin is paced by the
// one shared 32x32 multiplier (mu, log interpolation, ln2 scaling, x*ln) and
// the byte-per-cycle normaliser before each log2 lookup. the user must write
// amplitudes through csr_* only while no bin is in flight (not enforced).
// ----------------------------------------------------------------------------
module poisson_binned_neg2_loglik import pbnl_pkg::*; #(
   parameter int COUNT_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   pbnl_req_if.sink    req_chan,
   pbnl_rsp_if.source  rsp_chan,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   // amplitude registers
   logic [31:0] sig_amp_ff, sig_amp_in;
   logic [31:0] bkg_amp_ff, bkg_amp_in;

   // queue head between front and back
   logic        head_valid;
   item_type    head_item;
   logic        head_pop;

   always_comb begin
      sig_amp_in = sig_amp_ff;
      bkg_amp_in = bkg_amp_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SIGNAL_AMP:     sig_amp_in = csr_write_data;
            CSR_BACKGROUND_AMP: bkg_amp_in = csr_write_data;
            default: begin
               // writes past the register list are dropped
               sig_amp_in = sig_amp_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sig_amp_ff <= '0;
         bkg_amp_ff <= '0;
      end else begin
         sig_amp_ff <= sig_amp_in;
         bkg_amp_ff <= bkg_amp_in;
      end
   end

   // input side: count masking, empty-bin flag, queue
   pbnl_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop)
   );

   // sequencer: mu, logs, term, saturating sum, result register
   pbnl_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .signal_amplitude     (sig_amp_ff),
      .background_amplitude (bkg_amp_ff),
      .head_valid           (head_valid),
      .head_item            (head_item),
      .head_pop             (head_pop),
      .rsp_chan             (rsp_chan)
   );

endmodule

// ===== hdl/pbnl_checker.sv =====
// ----------------------------------------------------------------------------
// pbnl_checker
// port-level checks on the result channel of the deviance block
// ----------------------------------------------------------------------------
module pbnl_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [47:0] rsp_sum,
   input logic        rsp_sat,
   input logic [15:0] rsp_terms
);

   // a stalled result word stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // and keeps its contents
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_sum) && $stable(rsp_sat) && $stable(rsp_terms))
      else $error("result word changed while stalled");

   // saturation only comes from a counted term
   a_sat_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sat |-> rsp_terms != 16'd0)
      else $error("saturated with no term counted");

   // a nonzero sum needs at least one term
   a_sum_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sum != 48'd0 |-> rsp_terms != 16'd0)
      else $error("nonzero sum with no term counted");

endmodule

bind poisson_binned_neg2_loglik pbnl_checker u_pbnl_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_sum   (rsp_chan.neg2_log_likelihood),
   .rsp_sat   (rsp_chan.saturated),
   .rsp_terms (rsp_chan.terms_added)
);
